FILE: hdl/qte_pkg.sv
// shared constants, types and helpers for the quintic trajectory evaluator
`timescale 1ns / 1ps
package qte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int TIME_BITS = 8 + FRAC_BITS;
    localparam int TAU_BITS  = 30;
    localparam int TAU_W     = TAU_BITS + 1;
    localparam int POLY_W    = 33;
    localparam int MAG_W     = WORD_BITS + 1;
    localparam int DIV_X_W   = 38;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_LAT   = DIV_Q_W;
    localparam int TAU_LAT   = DIV_LAT + 3;
    localparam int LANE_LAT  = 3 + 2 * DIV_LAT + 1;
    localparam int NUM_AXES  = 3;

    localparam logic [TIME_BITS-1:0] TENTH_SEC =
        TIME_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [TAU_W-1:0] TAU_ONE  = TAU_W'(64'd1 << TAU_BITS);
    localparam logic [TAU_W-1:0] TAU_HALF = TAU_W'(64'd1 << (TAU_BITS - 1));
    localparam logic [MAG_W-1:0] MAG_CAP  = MAG_W'(64'd1 << WORD_BITS);
    localparam logic [DIV_Q_W-1:0] CAP_LIM =
        DIV_Q_W'((64'd1 << WORD_BITS) + (64'd1 << FRAC_BITS));
    localparam logic [MAG_W-1:0] HALF_RANGE = MAG_W'(64'd1 << (WORD_BITS - 1));

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [TIME_BITS-1:0]        t_time;
    typedef logic [POLY_W-1:0]           t_poly_val;

    typedef struct packed {
        t_poly_val spoly;
        t_poly_val vpoly;
        t_poly_val apoly;
        logic      aneg;
        t_time     teff;
    } t_poly;

    // quotient cap that matches the scaled divide
    function automatic logic [DIV_Q_W-1:0] cap_q(input logic [DIV_Q_W-1:0] q,
                                                  input logic ovf);
        if (ovf || (q >= CAP_LIM)) begin
            return DIV_Q_W'(MAG_CAP);
        end
        return q;
    endfunction

    // apply sign to a magnitude and saturate to the word range
    function automatic t_word sat_mag(input logic [DIV_Q_W-1:0] mag,
                                      input logic neg);
        logic [MAG_W-1:0] m;
        m = MAG_W'(mag);
        if (m >= HALF_RANGE) begin
            return neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return neg ? t_word'(-m[WORD_BITS-1:0]) : t_word'(m[WORD_BITS-1:0]);
    endfunction

endpackage

FILE: hdl/qte_div.sv
// pipelined restoring divider, floor(x * 2^FRAC_BITS / den), one quotient bit per stage
`timescale 1ns / 1ps
module qte_div (
    input  logic                           i_clk,
    input  logic [qte_pkg::DIV_X_W-1:0]   i_x,
    input  qte_pkg::t_time                 i_den,
    output logic [qte_pkg::DIV_Q_W-1:0]   o_q,
    output logic                           o_ovf,
    output qte_pkg::t_time                 o_den
);

    localparam int QW = qte_pkg::DIV_Q_W;
    localparam int RW = qte_pkg::TIME_BITS;
    localparam int HW = qte_pkg::DIV_X_W + qte_pkg::FRAC_BITS - QW;

    logic [RW-1:0]           r_rem [0:QW-1];
    logic [QW-1:0]           r_xl  [0:QW-1];
    logic [QW-1:0]           r_q   [0:QW-1];
    logic                    r_ovf [0:QW-1];
    qte_pkg::t_time          r_den [0:QW-1];

    logic [HW-1:0]           rem_init;
    logic [QW-1:0]           xl_init;

    assign rem_init = i_x[qte_pkg::DIV_X_W-1 -: HW];
    assign xl_init  = {i_x[QW-qte_pkg::FRAC_BITS-1:0], {qte_pkg::FRAC_BITS{1'b0}}};

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0]  pr_rem;
        logic [QW-1:0]  pr_xl;
        logic [QW-1:0]  pr_q;
        logic           pr_ovf;
        qte_pkg::t_time pr_den;
        logic [RW:0]    t;
        logic           ge;
        logic [RW:0]    diff;

        if (s == 0) begin : g_first
            assign pr_rem = RW'(rem_init);
            assign pr_xl  = xl_init;
            assign pr_q   = '0;
            assign pr_ovf = ({{(RW-HW){1'b0}}, rem_init} >= i_den);
            assign pr_den = i_den;
        end else begin : g_next
            assign pr_rem = r_rem[s-1];
            assign pr_xl  = r_xl[s-1];
            assign pr_q   = r_q[s-1];
            assign pr_ovf = r_ovf[s-1];
            assign pr_den = r_den[s-1];
        end

        assign t    = {pr_rem, pr_xl[QW-1-s]};
        assign ge   = (t >= {1'b0, pr_den});
        assign diff = t - {1'b0, pr_den};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? diff[RW-1:0] : t[RW-1:0];
            r_xl[s]  <= pr_xl;
            r_q[s]   <= {pr_q[QW-2:0], ge};
            r_ovf[s] <= pr_ovf;
            r_den[s] <= pr_den;
        end
    end

    assign o_q   = r_q[QW-1];
    assign o_ovf = r_ovf[QW-1];
    assign o_den = r_den[QW-1];

endmodule

FILE: hdl/qte_tau.sv
// normalized time and shared profile polynomials
`timescale 1ns / 1ps
module qte_tau (
    input  logic           i_clk,
    input  qte_pkg::t_time i_duration,
    input  qte_pkg::t_time i_elapsed,
    output qte_pkg::t_poly o_poly
);

    localparam int TW = qte_pkg::TAU_W;
    localparam int TB = qte_pkg::TAU_BITS;
    localparam int IW = 35;

    qte_pkg::t_time                 teff_in;
    logic [qte_pkg::DIV_X_W-1:0]    x_in;
    logic [qte_pkg::DIV_Q_W-1:0]    q;
    logic                           ovf;
    qte_pkg::t_time                 den;
    logic [TW-1:0]                  tau;
    logic [2*TW-1:0]                pp_tt;
    logic [2*TW-1:0]                pp_tu;

    logic [TW-1:0]                  r_tau;
    logic [TW-1:0]                  r_p2;
    logic [TW-1:0]                  r_w;
    qte_pkg::t_time                 r_teff_a;

    logic [2*TW-1:0]                pp_p3;
    logic [2*TW-1:0]                pp_ww;
    logic [2*TW-1:0]                pp_wm;
    logic                           aneg;
    logic [TW:0]                    tau2;
    logic [TW-1:0]                  m;
    logic [IW-1:0]                  inner;

    logic [TW-1:0]                  r_p3;
    logic [IW-1:0]                  r_inner;
    qte_pkg::t_poly_val             r_vpoly_b;
    qte_pkg::t_poly_val             r_apoly_b;
    logic                           r_aneg_b;
    qte_pkg::t_time                 r_teff_b;

    logic [TW+IW-1:0]               pp_s;
    qte_pkg::t_poly                 r_out;

    assign teff_in = (i_duration == '0) ? qte_pkg::TENTH_SEC : i_duration;
    assign x_in    = {i_elapsed, {(qte_pkg::DIV_X_W-qte_pkg::TIME_BITS){1'b0}}};

    qte_div u_div (
        .i_clk (i_clk),
        .i_x   (x_in),
        .i_den (teff_in),
        .o_q   (q),
        .o_ovf (ovf),
        .o_den (den)
    );

    assign tau   = (ovf || (q > qte_pkg::DIV_Q_W'(qte_pkg::TAU_ONE))) ? qte_pkg::TAU_ONE
                                                                      : q[TW-1:0];
    assign pp_tt = (2*TW)'(tau) * (2*TW)'(tau);
    assign pp_tu = (2*TW)'(tau) * (2*TW)'(qte_pkg::TAU_ONE - tau);

    always_ff @(posedge i_clk) begin
        r_tau    <= tau;
        r_p2     <= pp_tt[TB +: TW];
        r_w      <= pp_tu[TB +: TW];
        r_teff_a <= den;
    end

    assign aneg  = (r_tau > qte_pkg::TAU_HALF);
    assign tau2  = {r_tau, 1'b0};
    assign m     = aneg ? TW'(tau2 - {1'b0, qte_pkg::TAU_ONE})
                        : TW'({1'b0, qte_pkg::TAU_ONE} - tau2);
    assign pp_p3 = (2*TW)'(r_p2) * (2*TW)'(r_tau);
    assign pp_ww = (2*TW)'(r_w) * (2*TW)'(r_w);
    assign pp_wm = (2*TW)'(r_w) * (2*TW)'(m);
    assign inner = IW'(qte_pkg::TAU_ONE) * IW'(10) + IW'(r_p2) * IW'(6)
                 - IW'(r_tau) * IW'(15);

    always_ff @(posedge i_clk) begin
        r_p3      <= pp_p3[TB +: TW];
        r_inner   <= inner;
        r_vpoly_b <= qte_pkg::POLY_W'(qte_pkg::POLY_W'(pp_ww[TB +: TW]) * qte_pkg::POLY_W'(30));
        r_apoly_b <= qte_pkg::POLY_W'(qte_pkg::POLY_W'(pp_wm[TB +: TW]) * qte_pkg::POLY_W'(60));
        r_aneg_b  <= aneg;
        r_teff_b  <= r_teff_a;
    end

    assign pp_s = (TW+IW)'(r_p3) * (TW+IW)'(r_inner);

    always_ff @(posedge i_clk) begin
        r_out.spoly <= pp_s[TB +: qte_pkg::POLY_W];
        r_out.vpoly <= r_vpoly_b;
        r_out.apoly <= r_apoly_b;
        r_out.aneg  <= r_aneg_b;
        r_out.teff  <= r_teff_b;
    end

    assign o_poly = r_out;

endmodule

FILE: hdl/qte_lane.sv
// one axis: scale the profile by the move distance, divide by duration (twice for acceleration), saturate
`timescale 1ns / 1ps
module qte_lane (
    input  logic            i_clk,
    input  qte_pkg::t_word  i_start,
    input  qte_pkg::t_word  i_end,
    input  qte_pkg::t_poly  i_poly,
    output qte_pkg::t_word  o_pos,
    output qte_pkg::t_word  o_vel,
    output qte_pkg::t_word  o_acc
);

    localparam int MW = qte_pkg::MAG_W;
    localparam int PW = qte_pkg::POLY_W;
    localparam int LO = 17;
    localparam int HI = PW - LO;
    localparam int PRW = MW + PW;
    localparam int XW = qte_pkg::DIV_X_W;
    localparam int QW = qte_pkg::DIV_Q_W;
    localparam int DL = qte_pkg::DIV_LAT;

    logic signed [MW-1:0] d;

    logic [MW-1:0]        r_mag;
    logic                 r_neg1;
    qte_pkg::t_word       r_st1;
    qte_pkg::t_poly       r_poly1;

    logic [MW+LO-1:0]     r_sl, r_vl, r_al;
    logic [MW+HI-1:0]     r_sh, r_vh, r_ah;
    logic                 r_neg2;
    qte_pkg::t_word       r_st2;
    logic                 r_aneg2;
    qte_pkg::t_time       r_teff2;

    logic [PRW-1:0]       ps, pv, pa;
    logic [XW-1:0]        r_pm, r_vx, r_ax;
    logic                 r_neg3;
    qte_pkg::t_word       r_st3;
    logic                 r_aneg3;
    qte_pkg::t_time       r_teff3;

    logic [QW-1:0]        pm_cap;
    logic signed [MW+1:0] pos_sum;
    qte_pkg::t_word       pos_c;

    logic [QW-1:0]        vq, aq1, aq2;
    logic                 vovf, aovf1, aovf2;
    qte_pkg::t_time       vden, aden1, aden2;
    logic [XW-1:0]        ax2;
    qte_pkg::t_word       vel_c, acc_c;

    qte_pkg::t_word       r_pos_dl  [0:2*DL-1];
    logic                 r_sgn_dl  [0:2*DL-1];
    logic                 r_vneg_dl [0:DL-1];
    qte_pkg::t_word       r_vel_dl  [0:DL-1];

    qte_pkg::t_word       r_pos, r_vel, r_acc;

    assign d = MW'(i_end) - MW'(i_start);

    always_ff @(posedge i_clk) begin
        r_neg1  <= d[MW-1];
        r_mag   <= d[MW-1] ? MW'(-d) : MW'(d);
        r_st1   <= i_start;
        r_poly1 <= i_poly;
    end

    always_ff @(posedge i_clk) begin
        r_sl    <= (MW+LO)'(r_mag) * (MW+LO)'(r_poly1.spoly[LO-1:0]);
        r_sh    <= (MW+HI)'(r_mag) * (MW+HI)'(r_poly1.spoly[PW-1:LO]);
        r_vl    <= (MW+LO)'(r_mag) * (MW+LO)'(r_poly1.vpoly[LO-1:0]);
        r_vh    <= (MW+HI)'(r_mag) * (MW+HI)'(r_poly1.vpoly[PW-1:LO]);
        r_al    <= (MW+LO)'(r_mag) * (MW+LO)'(r_poly1.apoly[LO-1:0]);
        r_ah    <= (MW+HI)'(r_mag) * (MW+HI)'(r_poly1.apoly[PW-1:LO]);
        r_neg2  <= r_neg1;
        r_st2   <= r_st1;
        r_aneg2 <= r_poly1.aneg;
        r_teff2 <= r_poly1.teff;
    end

    assign ps = {r_sh, {LO{1'b0}}} + PRW'(r_sl);
    assign pv = {r_vh, {LO{1'b0}}} + PRW'(r_vl);
    assign pa = {r_ah, {LO{1'b0}}} + PRW'(r_al);

    always_ff @(posedge i_clk) begin
        r_pm    <= XW'(ps[PRW-1:qte_pkg::TAU_BITS]);
        r_vx    <= XW'(pv[PRW-1:qte_pkg::TAU_BITS]);
        r_ax    <= XW'(pa[PRW-1:qte_pkg::TAU_BITS]);
        r_neg3  <= r_neg2;
        r_st3   <= r_st2;
        r_aneg3 <= r_aneg2;
        r_teff3 <= r_teff2;
    end

    // position offset, magnitude capped before the sign goes on
    assign pm_cap  = (r_pm > XW'(qte_pkg::MAG_CAP)) ? QW'(qte_pkg::MAG_CAP) : r_pm[QW-1:0];
    assign pos_sum = (MW+2)'(r_st3) + (r_neg3 ? -(MW+2)'(pm_cap) : (MW+2)'(pm_cap));
    always_comb begin
        if (pos_sum > (MW+2)'(signed'({1'b0, {(qte_pkg::WORD_BITS-1){1'b1}}}))) begin
            pos_c = {1'b0, {(qte_pkg::WORD_BITS-1){1'b1}}};
        end else if (pos_sum < -(MW+2)'(signed'(qte_pkg::HALF_RANGE))) begin
            pos_c = {1'b1, {(qte_pkg::WORD_BITS-1){1'b0}}};
        end else begin
            pos_c = pos_sum[qte_pkg::WORD_BITS-1:0];
        end
    end

    qte_div u_vdiv (
        .i_clk (i_clk),
        .i_x   (r_vx),
        .i_den (r_teff3),
        .o_q   (vq),
        .o_ovf (vovf),
        .o_den (vden)
    );

    qte_div u_adiv1 (
        .i_clk (i_clk),
        .i_x   (r_ax),
        .i_den (r_teff3),
        .o_q   (aq1),
        .o_ovf (aovf1),
        .o_den (aden1)
    );

    assign ax2 = XW'(qte_pkg::cap_q(aq1, aovf1));

    qte_div u_adiv2 (
        .i_clk (i_clk),
        .i_x   (ax2),
        .i_den (aden1),
        .o_q   (aq2),
        .o_ovf (aovf2),
        .o_den (aden2)
    );

    assign vel_c = qte_pkg::sat_mag(qte_pkg::cap_q(vq, vovf), r_vneg_dl[DL-1]);
    assign acc_c = qte_pkg::sat_mag(qte_pkg::cap_q(aq2, aovf2), r_sgn_dl[2*DL-1]);

    always_ff @(posedge i_clk) begin
        r_pos_dl[0]  <= pos_c;
        r_sgn_dl[0]  <= r_neg3 ^ r_aneg3;
        r_vneg_dl[0] <= r_neg3;
        r_vel_dl[0]  <= vel_c;
        for (int k = 1; k < 2*DL; k++) begin
            r_pos_dl[k] <= r_pos_dl[k-1];
            r_sgn_dl[k] <= r_sgn_dl[k-1];
        end
        for (int k = 1; k < DL; k++) begin
            r_vneg_dl[k] <= r_vneg_dl[k-1];
            r_vel_dl[k]  <= r_vel_dl[k-1];
        end
        r_pos <= r_pos_dl[2*DL-1];
        r_vel <= r_vel_dl[DL-1];
        r_acc <= (aden2 == '0) ? acc_c : acc_c;
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_acc = r_acc;

endmodule

FILE: hdl/quintic_trajectory_eval_core.sv
// top level: three-axis minimum-jerk trajectory evaluator
`timescale 1ns / 1ps
// usage
//   a query is taken at a rising edge with start high and busy low; busy is
//   held low, so a new query may be issued every cycle
//   the query carries start and end points for x, y and z (signed Q16.16),
//   the segment duration and the elapsed time (unsigned Q8.16)
//   each result appears on the o_ ports for exactly one cycle with o_valid
//   high; there is no back pressure, the receiver takes every result
//   throughput is one query per cycle
//   latency is set by the 33-stage divider for the normalized time followed
//   by two chained 33-stage dividers per axis for acceleration
//   results leave in query order
//   reset (synchronous, active low) clears the valid pipeline; queries in
//   flight are dropped and no result is shown until new queries arrive
//   elapsed beyond duration returns the end point, zero velocity and
//   acceleration, and sets o_past_end
module quintic_trajectory_eval_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  qte_pkg::t_word i_start_x,
    input  qte_pkg::t_word i_start_y,
    input  qte_pkg::t_word i_start_z,
    input  qte_pkg::t_word i_end_x,
    input  qte_pkg::t_word i_end_y,
    input  qte_pkg::t_word i_end_z,
    input  qte_pkg::t_time i_duration,
    input  qte_pkg::t_time i_elapsed,
    output logic           o_valid,
    output qte_pkg::t_word o_pos_x,
    output qte_pkg::t_word o_pos_y,
    output qte_pkg::t_word o_pos_z,
    output qte_pkg::t_word o_vel_x,
    output qte_pkg::t_word o_vel_y,
    output qte_pkg::t_word o_vel_z,
    output qte_pkg::t_word o_acc_x,
    output qte_pkg::t_word o_acc_y,
    output qte_pkg::t_word o_acc_z,
    output logic           o_past_end
);

    localparam int NA  = qte_pkg::NUM_AXES;
    localparam int TL  = qte_pkg::TAU_LAT;
    localparam int ML  = qte_pkg::TAU_LAT + qte_pkg::LANE_LAT;
    localparam int LAT = ML + 1;

    logic           accept;
    qte_pkg::t_poly poly;
    qte_pkg::t_word st_in [0:NA-1];
    qte_pkg::t_word en_in [0:NA-1];
    qte_pkg::t_word l_pos [0:NA-1];
    qte_pkg::t_word l_vel [0:NA-1];
    qte_pkg::t_word l_acc [0:NA-1];

    logic           r_vld_dl  [0:ML-1];
    logic           r_past_dl [0:ML-1];
    qte_pkg::t_word r_st_dl   [0:TL-1][0:NA-1];
    qte_pkg::t_word r_en_dl   [0:ML-1][0:NA-1];

    logic           r_valid;
    logic           r_past;
    qte_pkg::t_word r_pos [0:NA-1];
    qte_pkg::t_word r_vel [0:NA-1];
    qte_pkg::t_word r_acc [0:NA-1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign st_in[0] = i_start_x;
    assign st_in[1] = i_start_y;
    assign st_in[2] = i_start_z;
    assign en_in[0] = i_end_x;
    assign en_in[1] = i_end_y;
    assign en_in[2] = i_end_z;

    qte_tau u_tau (
        .i_clk      (i_clk),
        .i_duration (i_duration),
        .i_elapsed  (i_elapsed),
        .o_poly     (poly)
    );

    for (genvar a = 0; a < NA; a++) begin : g_lane
        qte_lane u_lane (
            .i_clk   (i_clk),
            .i_start (r_st_dl[TL-1][a]),
            .i_end   (r_en_dl[TL-1][a]),
            .i_poly  (poly),
            .o_pos   (l_pos[a]),
            .o_vel   (l_vel[a]),
            .o_acc   (l_acc[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ML; k++) begin
                r_vld_dl[k] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else begin
            r_vld_dl[0] <= accept;
            for (int k = 1; k < ML; k++) begin
                r_vld_dl[k] <= r_vld_dl[k-1];
            end
            r_valid <= r_vld_dl[ML-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_past_dl[0] <= (i_elapsed > i_duration);
        for (int a = 0; a < NA; a++) begin
            r_st_dl[0][a] <= st_in[a];
            r_en_dl[0][a] <= en_in[a];
        end
        for (int k = 1; k < TL; k++) begin
            r_st_dl[k] <= r_st_dl[k-1];
        end
        for (int k = 1; k < ML; k++) begin
            r_past_dl[k] <= r_past_dl[k-1];
            r_en_dl[k]   <= r_en_dl[k-1];
        end
        // merge lanes; once past the segment, hold the end point and zero velocity and acceleration
        r_past <= r_past_dl[ML-1];
        for (int a = 0; a < NA; a++) begin
            r_pos[a] <= r_past_dl[ML-1] ? r_en_dl[ML-1][a] : l_pos[a];
            r_vel[a] <= r_past_dl[ML-1] ? '0 : l_vel[a];
            r_acc[a] <= r_past_dl[ML-1] ? '0 : l_acc[a];
        end
    end

    assign o_valid    = r_valid;
    assign o_past_end = r_past;
    assign o_pos_x    = r_pos[0];
    assign o_pos_y    = r_pos[1];
    assign o_pos_z    = r_pos[2];
    assign o_vel_x    = r_vel[0];
    assign o_vel_y    = r_vel[1];
    assign o_vel_z    = r_vel[2];
    assign o_acc_x    = r_acc[0];
    assign o_acc_y    = r_acc[1];
    assign o_acc_z    = r_acc[2];

`ifndef SYNTHESIS
    a_valid_has_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching query");

    a_past_holds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_past_end) |-> (o_pos_x == $past(i_end_x, LAT)))
        else $error("held end point does not match the query");

    a_past_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_past_end == ($past(i_elapsed, LAT) > $past(i_duration, LAT))))
        else $error("past-end flag does not match the query times");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the quintic trajectory evaluator core
`timescale 1ns / 1ps
module tb_top;

    localparam int LATENCY   = 107;
    localparam int N_RANDOM  = 1950;
    localparam int CYCLE_MAX = 400000;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] CAP     = 64'd1 << 32;
    localparam logic [63:0] TENTH   = 64'd6554;

    typedef struct {
        qte_pkg::t_word sx, sy, sz, ex, ey, ez;
        qte_pkg::t_time dur, el;
    } t_query;

    typedef struct {
        qte_pkg::t_word pos [3];
        qte_pkg::t_word vel [3];
        qte_pkg::t_word acc [3];
        logic  past;
    } t_setpoint;

    logic  i_clk, i_rst_n, start, busy, o_valid, o_past_end;
    qte_pkg::t_word i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z;
    qte_pkg::t_time i_duration, i_elapsed;
    qte_pkg::t_word o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;
    qte_pkg::t_word o_acc_x, o_acc_y, o_acc_z;

    t_setpoint pending_setpoints[$];
    int  errors;
    int  cycles;
    int  send_idle_pct;

    quintic_trajectory_eval_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // floor(a * b / 2^30)
    function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
        return (a >> 30) * b + (((a & (Q30_ONE - 1)) * b) >> 30);
    endfunction

    function automatic logic [63:0] frac_div(logic [63:0] x, logic [63:0] den);
        logic [63:0] q;
        q = x / den;
        if (q > (CAP >> 16)) return CAP;
        return (q << 16) + (((x % den) << 16) / den);
    endfunction

    function automatic qte_pkg::t_word clamp_word(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return qte_pkg::t_word'(v);
    endfunction

    function automatic longint apply_sign(logic [63:0] mag, bit neg);
        if (mag > CAP) mag = CAP;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic t_setpoint min_jerk_setpoint(t_query q);
        t_setpoint r;
        logic [63:0] teff, tau, u, p2, p3, inner, spoly, w, vpoly, m, apoly, mag;
        logic [63:0] pm, vm, am;
        longint st [3];
        longint en [3];
        longint d;
        bit aneg, neg;
        st = '{longint'(q.sx), longint'(q.sy), longint'(q.sz)};
        en = '{longint'(q.ex), longint'(q.ey), longint'(q.ez)};
        r.past = q.el > q.dur;
        if (r.past) begin
            for (int i = 0; i < 3; i++) begin
                r.pos[i] = qte_pkg::t_word'(en[i]);
                r.vel[i] = '0;
                r.acc[i] = '0;
            end
            return r;
        end
        teff = (q.dur == 0) ? TENTH : 64'(q.dur);
        tau = (64'(q.el) << 30) / teff;
        if (tau > Q30_ONE) tau = Q30_ONE;
        u = Q30_ONE - tau;
        p2 = (tau * tau) >> 30;
        p3 = (p2 * tau) >> 30;
        inner = 10 * Q30_ONE + 6 * p2 - 15 * tau;
        spoly = (p3 * inner) >> 30;
        w = (tau * u) >> 30;
        vpoly = 30 * ((w * w) >> 30);
        aneg = tau > (Q30_ONE >> 1);
        m = aneg ? (2 * tau - Q30_ONE) : (Q30_ONE - 2 * tau);
        apoly = 60 * ((w * m) >> 30);
        for (int i = 0; i < 3; i++) begin
            d = en[i] - st[i];
            neg = d < 0;
            mag = neg ? 64'(-d) : 64'(d);
            pm = q30_mul(mag, spoly);
            vm = frac_div(q30_mul(mag, vpoly), teff);
            am = frac_div(frac_div(q30_mul(mag, apoly), teff), teff);
            r.pos[i] = clamp_word(st[i] + apply_sign(pm, neg));
            r.vel[i] = clamp_word(apply_sign(vm, neg));
            r.acc[i] = clamp_word(apply_sign(am, neg != aneg));
        end
        return r;
    endfunction

    function automatic qte_pkg::t_word rand_coord();
        case ($urandom_range(5))
            0: return qte_pkg::t_word'($urandom);
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return qte_pkg::t_word'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        q.sx = rand_coord(); q.sy = rand_coord(); q.sz = rand_coord();
        q.ex = rand_coord(); q.ey = rand_coord(); q.ez = rand_coord();
        case ($urandom_range(9))
            0: q.dur = '0;
            1: q.dur = qte_pkg::t_time'($urandom);
            2: q.dur = qte_pkg::t_time'($urandom_range(40));
            default: q.dur = qte_pkg::t_time'($urandom_range(20 << 16, 1 << 12));
        endcase
        case ($urandom_range(9))
            0: q.el = qte_pkg::t_time'($urandom);
            1: q.el = q.dur;
            2: q.el = q.dur + 24'd1;
            3: q.el = '0;
            default: q.el = (q.dur == 0) ? qte_pkg::t_time'($urandom_range(1))
                                         : qte_pkg::t_time'($urandom_range(q.dur));
        endcase
        return q;
    endfunction

    // one transfer, with optional typed-in expectation
    task automatic send_query(t_query q, bit known, t_setpoint ks);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_start_x  <= q.sx; i_start_y <= q.sy; i_start_z <= q.sz;
        i_end_x    <= q.ex; i_end_y   <= q.ey; i_end_z   <= q.ez;
        i_duration <= q.dur; i_elapsed <= q.el;
        do @(posedge i_clk); while (busy);
        pending_setpoints.push_back(known ? ks : min_jerk_setpoint(q));
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_setpoints.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_setpoint e;
        qte_pkg::t_word got [9];
        qte_pkg::t_word want [9];
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_setpoints.size() == 0) begin
                errors++;
                $display("%0t: unexpected result", $time);
            end else begin
                e = pending_setpoints.pop_front();
                got  = '{o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z,
                         o_acc_x, o_acc_y, o_acc_z};
                want = '{e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2],
                         e.acc[0], e.acc[1], e.acc[2]};
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want[i]) begin
                        errors++;
                        $display("%0t: field %0d expected %h actual %h",
                                 $time, i, want[i], got[i]);
                    end
                if (o_past_end !== e.past) begin
                    errors++;
                    $display("%0t: past_end expected %b actual %b",
                             $time, e.past, o_past_end);
                end
            end
        end
    end

    always @(posedge i_clk)
        if (cycles > CYCLE_MAX) begin
            $display("Regression FAIL");
            $finish;
        end

    typedef struct {
        t_query q;
        bit     known;
        t_setpoint s;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(t_query q, bit known, t_setpoint s);
        t_row r;
        r.q = q; r.known = known; r.s = s;
        directed_rows.push_back(r);
    endtask

    function automatic t_setpoint at_rest(qte_pkg::t_word x, qte_pkg::t_word y,
                                          qte_pkg::t_word z, bit past);
        t_setpoint s;
        s.pos = '{x, y, z};
        s.vel = '{0, 0, 0};
        s.acc = '{0, 0, 0};
        s.past = past;
        return s;
    endfunction

    initial begin
        t_query q;
        qte_pkg::t_word mx, mn;
        mx = 32'h7fffffff; mn = 32'h80000000;
        errors = 0; cycles = 0; send_idle_pct = 21;
        start = 0; i_rst_n = 0;
        {i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z} = '0;
        i_duration = '0; i_elapsed = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // start of segment, end held, zero duration, extreme coordinates, tiny durations and mid-segment cases
        q = '{1 << 16, -(2 << 16), 0, 5 << 16, 7 << 16, -(3 << 16), 24'h010000, 24'd0};
        add_row(q, 1, at_rest(1 << 16, -(2 << 16), 0, 0));
        q.el = 24'h010001;
        add_row(q, 1, at_rest(5 << 16, 7 << 16, -(3 << 16), 1));
        q.dur = 24'd0; q.el = 24'd0;
        add_row(q, 1, at_rest(1 << 16, -(2 << 16), 0, 0));
        q.el = 24'd1;
        add_row(q, 1, at_rest(5 << 16, 7 << 16, -(3 << 16), 1));
        q.dur = 24'hffffff; q.el = 24'hffffff;
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q = '{mn, mx, mn, mx, mn, mn, 24'hffffff, 24'hffffff};
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q.dur = 24'd1; q.el = 24'd0;
        add_row(q, 1, at_rest(mn, mx, mn, 0));
        q.el = 24'd1;
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q.dur = 24'd3; q.el = 24'd1;
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q.dur = 24'd2; q.el = 24'd1;
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q = '{mx, mn, 0, mn, mx, 0, 24'h000001, 24'hffffff};
        add_row(q, 1, at_rest(mn, mx, 0, 1));
        q = '{0, 0, 0, 10 << 16, -(10 << 16), 1, 24'd0, 24'd3277};
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q.dur = 24'h800000; q.el = 24'h400000;
        add_row(q, 0, at_rest(0, 0, 0, 0));
        q.el = 24'h7fffff;
        add_row(q, 0, at_rest(0, 0, 0, 0));

        foreach (directed_rows[i])
            send_query(directed_rows[i].q, directed_rows[i].known, directed_rows[i].s);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) send_idle_pct = 50;
            if (i == 2 * N_RANDOM / 3) send_idle_pct = 0;
            if (i == N_RANDOM / 2) drain();
            send_query(rand_query(), 0, at_rest(0, 0, 0, 0));
        end
        drain();
        repeat (LATENCY + 20) @(negedge i_clk);
        if (errors == 0 && pending_setpoints.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/qte_pkg.sv
hdl/qte_div.sv
hdl/qte_tau.sv
hdl/qte_lane.sv
hdl/quintic_trajectory_eval_core.sv
tb/sv/tb_top.sv
